// ----- rtl/fpfa_pkg.sv -----
// Shared types, constants and codes of the fixed partition fit allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fpfa_pkg;

   // Table geometry
   localparam int PARTS    = 16;
   localparam int SIZE_W   = 16;
   localparam int IDX_W    = $clog2(PARTS);
   localparam int CNT_W    = $clog2(PARTS + 1);

   // Widths of the slot field and the fit policy
   localparam int SLOT_W   = 4;
   localparam int POLICY_W = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_FIT_POLICY    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PARTS_IN_USE  = CSR_IDX_W'(1);

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   // Fit policies
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // Search record that walks down the cell chain
   typedef struct packed {
      logic              active;
      logic              found;
      logic [IDX_W-1:0]  pick;
      logic [SIZE_W-1:0] best;
   } scan_rec_type;

   // Search terms broadcast to every cell while a scan runs
   typedef struct packed {
      logic [SIZE_W-1:0]   amount;
      logic [POLICY_W-1:0] policy;
      logic [CNT_W-1:0]    count;
   } search_ctl_type;

   // Table write broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [SIZE_W-1:0] value;
   } cell_write_type;

endpackage

`default_nettype wire

// ----- rtl/fpfa_cell.sv -----
// One partition cell: holds the free space of one partition and updates
// the passing search record. Depends on fpfa_pkg.
`default_nettype none

module fpfa_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [fpfa_pkg::IDX_W-1:0] cell_index,
   input  wire fpfa_pkg::search_ctl_type   search,
   input  wire fpfa_pkg::cell_write_type   wr,
   input  wire fpfa_pkg::scan_rec_type     rec_prev,
   output fpfa_pkg::scan_rec_type          rec_next
);
   import fpfa_pkg::*;

   logic [SIZE_W-1:0] space_ff, space_in;
   scan_rec_type      rec_ff, rec_in;
   logic              in_use;
   logic              fits;
   logic              take;

   assign in_use = CNT_W'(cell_index) < search.count;
   assign fits   = in_use && (space_ff >= search.amount);

   always_comb begin
      case (search.policy)
         POLICY_FIRST: take = fits && !rec_prev.found;
         POLICY_BEST:  take = fits && (!rec_prev.found || space_ff < rec_prev.best);
         POLICY_WORST: take = fits && (!rec_prev.found || space_ff > rec_prev.best);
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      rec_in = rec_prev;
      if (rec_prev.active && take) begin
         rec_in.found = 1'b1;
         rec_in.pick  = cell_index;
         rec_in.best  = space_ff;
      end
   end

   assign space_in = (wr.en && wr.idx == cell_index) ? wr.value : space_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff <= '0;
         rec_ff   <= '0;
      end else begin
         space_ff <= space_in;
         rec_ff   <= rec_in;
      end
   end

   assign rec_next = rec_ff;

endmodule

`default_nettype wire

// ----- rtl/fpfa_ctrl.sv -----
// Sequencer of the allocator: request intake, configuration registers,
// scan launch, table write-back and the response register. Depends on fpfa_pkg.
`default_nettype none

module fpfa_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [fpfa_pkg::SLOT_W-1:0]       req_slot,
   input  wire logic [fpfa_pkg::SIZE_W-1:0]       req_amount,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_granted,
   output logic [fpfa_pkg::SLOT_W-1:0]            rsp_slot_chosen,
   output logic [fpfa_pkg::SIZE_W-1:0]            rsp_space_left,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fpfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fpfa_pkg::CSR_DATA_W-1:0]   csr_data,
   output fpfa_pkg::scan_rec_type                 launch,
   output fpfa_pkg::search_ctl_type               search,
   output fpfa_pkg::cell_write_type               wr,
   input  wire fpfa_pkg::scan_rec_type            chain_out
);
   import fpfa_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   scan_rec_type        launch_ff, launch_in;
   logic [SIZE_W-1:0]   amount_ff, amount_in;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pend_granted_ff, pend_granted_in;
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [SIZE_W-1:0]   pend_space_ff, pend_space_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [SIZE_W-1:0]   rsp_space_ff;
   logic                accept;
   logic                out_free;
   logic                load_ok;
   logic [SIZE_W-1:0]   remain;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_ok   = {1'b0, req_slot} < (SLOT_W + 1)'(PARTS);
   assign remain    = chain_out.best - amount_ff;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FIT_POLICY:   policy_in = csr_data[POLICY_W-1:0];
            REG_PARTS_IN_USE: count_in  = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      launch_in       = '0;
      amount_in       = amount_ff;
      pend_granted_in = pend_granted_ff;
      pend_slot_in    = pend_slot_ff;
      pend_space_in   = pend_space_ff;
      wr              = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  wr.en           = load_ok;
                  wr.idx          = req_slot[IDX_W-1:0];
                  wr.value        = req_amount;
                  pend_granted_in = load_ok;
                  pend_slot_in    = load_ok ? req_slot : '0;
                  pend_space_in   = load_ok ? req_amount : '0;
                  state_in        = ST_EMIT;
               end else begin
                  amount_in        = req_amount;
                  launch_in.active = 1'b1;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (chain_out.active) begin
               wr.en           = chain_out.found;
               wr.idx          = chain_out.pick;
               wr.value        = remain;
               pend_granted_in = chain_out.found;
               pend_slot_in    = chain_out.found ? SLOT_W'(chain_out.pick) : '0;
               pend_space_in   = chain_out.found ? remain : '0;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_EMIT) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         policy_ff    <= POLICY_FIRST;
         count_ff     <= CNT_W'(PARTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amount_ff       <= amount_in;
      pend_granted_ff <= pend_granted_in;
      pend_slot_ff    <= pend_slot_in;
      pend_space_ff   <= pend_space_in;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_granted_ff <= pend_granted_ff;
         rsp_slot_ff    <= pend_slot_ff;
         rsp_space_ff   <= pend_space_ff;
      end
   end

   assign launch          = launch_ff;
   assign search.amount   = amount_ff;
   assign search.policy   = policy_ff;
   assign search.count    = count_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_slot_chosen = rsp_slot_ff;
   assign rsp_space_left  = rsp_space_ff;

endmodule

`default_nettype wire

// ----- rtl/fixed_partition_fit_allocator_core.sv -----
// Top level of the fixed partition fit allocator: sequencer plus a chain of
// partition cells. Depends on fpfa_pkg, fpfa_ctrl and fpfa_cell.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   req_    | in        | req_valid/req_stall  | kind, slot, amount
//   rsp_    | out       | rsp_valid/rsp_stall  | granted, slot_chosen, space_left
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A load request writes the table at accept; the response then passes through the
// pending registers and leaves through the output register.
// An allocate request launches a search record that walks one cell per cycle down
// the chain, then write-back and response; one request is in work at a time.
// Reset (synchronous) zeroes every partition, sets first fit and all partitions in use.
// A stalled response holds in the output register while the next request is taken.
`default_nettype none

module fixed_partition_fit_allocator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_kind,
   input  wire logic [fpfa_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [fpfa_pkg::SIZE_W-1:0]     req_amount,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_granted,
   output logic [fpfa_pkg::SLOT_W-1:0]          rsp_slot_chosen,
   output logic [fpfa_pkg::SIZE_W-1:0]          rsp_space_left,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fpfa_pkg::CSR_DATA_W-1:0] csr_data
);
   import fpfa_pkg::*;

   // rec_link[i] feeds cell i; rec_link[PARTS] returns to the sequencer
   scan_rec_type   rec_link [PARTS+1];
   search_ctl_type search;
   cell_write_type wr;

   fpfa_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_slot_chosen (rsp_slot_chosen),
      .rsp_space_left  (rsp_space_left),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .launch          (rec_link[0]),
      .search          (search),
      .wr              (wr),
      .chain_out       (rec_link[PARTS])
   );

   // Cell chain: each cell owns one partition, lowest index first so that
   // ties in best and worst fit keep the earliest candidate
   for (genvar i = 0; i < PARTS; i++) begin : g_cell
      fpfa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .search     (search),
         .wr         (wr),
         .rec_prev   (rec_link[i]),
         .rec_next   (rec_link[i+1])
      );
   end

endmodule

`default_nettype wire

// ----- rtl/fpfa_checker.sv -----
// Port-level checks of the allocator core, attached by bind.
// Depends on fpfa_pkg and fixed_partition_fit_allocator_core.
`default_nettype none

module fpfa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_granted,
   input wire logic [fpfa_pkg::SLOT_W-1:0]     rsp_slot_chosen,
   input wire logic [fpfa_pkg::SIZE_W-1:0]     rsp_space_left
);
   import fpfa_pkg::*;

   // A refused request carries no partition and no space
   a_refusal_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_slot_chosen == '0 && rsp_space_left == '0)
      else $error("refused response carries nonzero fields");

   // Reset leaves no response pending
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // One request in work at a time: intake closes after an accept
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while the first is in work");

   // A stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted)
         && $stable(rsp_slot_chosen) && $stable(rsp_space_left))
      else $error("stalled response changed");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (.*);

`default_nettype wire
